### rtl/core/nsfe_pkg.sv
// ----------------------------------------------------------------------------
// nsfe_pkg: shared types and constants of the NMEA sentence field extractor
// Header strings, special characters, limits and the slot mapping result.
// ----------------------------------------------------------------------------
package nsfe_pkg;

	// Sentence limits
	localparam int unsigned MAX_SENTENCE = 82;
	localparam int unsigned HDR_LEN      = 6;
	localparam logic [3:0]  COMMA_SAT    = 4'd11;
	localparam logic [3:0]  FIELD_SAT    = 4'd15;
	localparam logic [3:0]  COMMA_LAST   = 4'd9;

	// Special characters
	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	// Header strings, first character in the top byte
	localparam logic [47:0] HDR_RMC = "$GPRMC";
	localparam logic [47:0] HDR_GGA = "$GPGGA";

	// Sentence type codes
	localparam logic SEL_RMC = 1'b0;
	localparam logic SEL_GGA = 1'b1;

	// Configuration register indexes
	localparam logic REG_SENTENCE_SELECT = 1'b0;

	// Slot codes
	localparam logic [4:0] SLOT_HOUR      = 5'd0;
	localparam logic [4:0] SLOT_VALID     = 5'd3;
	localparam logic [4:0] SLOT_LAT_DEG   = 5'd4;
	localparam logic [4:0] SLOT_LAT_NS    = 5'd6;
	localparam logic [4:0] SLOT_LON_DEG   = 5'd7;
	localparam logic [4:0] SLOT_LON_EW    = 5'd9;
	localparam logic [4:0] SLOT_SPEED     = 5'd10;
	localparam logic [4:0] SLOT_DAY       = 5'd11;
	localparam logic [4:0] SLOT_SATS      = 5'd14;
	localparam logic [4:0] SLOT_ACCURACY  = 5'd15;
	localparam logic [4:0] SLOT_ALTITUDE  = 5'd16;
	localparam logic [4:0] SLOT_ALT_UNIT  = 5'd17;

	// Result of the slot lookup
	typedef struct packed {
		logic       hit;
		logic [4:0] slot;
		logic [2:0] idx;
	} map_res_t;

	// Expected header character at position pos for the selected type
	function automatic logic [7:0] hdr_char(input logic sel, input logic [2:0] pos);
		logic [47:0] hdr;
		hdr = (sel == SEL_GGA) ? HDR_GGA : HDR_RMC;
		return hdr[(3'd5 - pos) * 8 +: 8];
	endfunction

endpackage

### rtl/core/nsfe_slot_map.sv
// ----------------------------------------------------------------------------
// nsfe_slot_map: field to slot lookup
// Maps comma count and position in field to a slot and a character index.
// ----------------------------------------------------------------------------
module nsfe_slot_map (
	input  logic                  sentence_select,
	input  logic [3:0]            comma_count,
	input  logic [3:0]            field_position,
	output nsfe_pkg::map_res_t    res
);

	// Three two-character slots (hh mm ss, dd mm yy)
	function automatic nsfe_pkg::map_res_t map_triple(input logic [3:0] f,
			input logic [4:0] base);
		nsfe_pkg::map_res_t r;
		r = '0;
		if (f < 4'd2) begin
			r = '{hit: 1'b1, slot: base, idx: f[2:0]};
		end else if (f < 4'd4) begin
			r = '{hit: 1'b1, slot: base + 5'd1, idx: 3'(f - 4'd2)};
		end else if (f < 4'd6) begin
			r = '{hit: 1'b1, slot: base + 5'd2, idx: 3'(f - 4'd4)};
		end
		return r;
	endfunction

	// Degrees then minutes
	function automatic nsfe_pkg::map_res_t map_coord(input logic [3:0] f,
			input logic [3:0] dlen, input logic [3:0] mend, input logic [4:0] base);
		nsfe_pkg::map_res_t r;
		r = '0;
		if (f < dlen) begin
			r = '{hit: 1'b1, slot: base, idx: f[2:0]};
		end else if (f < mend) begin
			r = '{hit: 1'b1, slot: base + 5'd1, idx: 3'(f - dlen)};
		end
		return r;
	endfunction

	// One slot of up to lim characters
	function automatic nsfe_pkg::map_res_t map_single(input logic [3:0] f,
			input logic [3:0] lim, input logic [4:0] s);
		nsfe_pkg::map_res_t r;
		r = '0;
		if (f < lim) begin
			r = '{hit: 1'b1, slot: s, idx: f[2:0]};
		end
		return r;
	endfunction

	// Lookup per sentence type
	always_comb begin
		res = '0;
		if (sentence_select == nsfe_pkg::SEL_GGA) begin
			unique case (comma_count)
				4'd1:    res = map_triple(field_position, nsfe_pkg::SLOT_HOUR);
				4'd2:    res = map_coord(field_position, 4'd2, 4'd9, nsfe_pkg::SLOT_LAT_DEG);
				4'd3:    res = map_single(field_position, 4'd1, nsfe_pkg::SLOT_LAT_NS);
				4'd4:    res = map_coord(field_position, 4'd3, 4'd10, nsfe_pkg::SLOT_LON_DEG);
				4'd5:    res = map_single(field_position, 4'd1, nsfe_pkg::SLOT_LON_EW);
				4'd7:    res = map_single(field_position, 4'd2, nsfe_pkg::SLOT_SATS);
				4'd8:    res = map_single(field_position, 4'd3, nsfe_pkg::SLOT_ACCURACY);
				4'd9:    res = map_single(field_position, 4'd5, nsfe_pkg::SLOT_ALTITUDE);
				4'd10:   res = map_single(field_position, 4'd1, nsfe_pkg::SLOT_ALT_UNIT);
				default: res = '0;
			endcase
		end else begin
			unique case (comma_count)
				4'd1:    res = map_triple(field_position, nsfe_pkg::SLOT_HOUR);
				4'd2:    res = map_single(field_position, 4'd1, nsfe_pkg::SLOT_VALID);
				4'd3:    res = map_coord(field_position, 4'd2, 4'd9, nsfe_pkg::SLOT_LAT_DEG);
				4'd4:    res = map_single(field_position, 4'd1, nsfe_pkg::SLOT_LAT_NS);
				4'd5:    res = map_coord(field_position, 4'd3, 4'd10, nsfe_pkg::SLOT_LON_DEG);
				4'd6:    res = map_single(field_position, 4'd1, nsfe_pkg::SLOT_LON_EW);
				4'd7:    res = map_single(field_position, 4'd5, nsfe_pkg::SLOT_SPEED);
				4'd9:    res = map_triple(field_position, nsfe_pkg::SLOT_DAY);
				default: res = '0;
			endcase
		end
	end

endmodule

### rtl/core/nsfe_parser.sv
// ----------------------------------------------------------------------------
// nsfe_parser: sentence tracking state
// Header check, comma and field counters, stop conditions, slot lookup.
// ----------------------------------------------------------------------------
module nsfe_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         byte_in,
	input  logic               first,
	input  logic               sentence_select,
	output logic               emit,
	output nsfe_pkg::map_res_t res
);

	logic [7:0] byte_pos_q;
	logic [3:0] comma_cnt_q;
	logic [3:0] field_pos_q;
	logic       header_ok_q;
	logic       stopped_q;

	// state seen by this item, after a possible restart
	logic [7:0] bp_cur;
	logic [3:0] cc_cur;
	logic [3:0] fp_cur;
	logic       hok_cur;
	logic       stp_cur;

	logic [7:0] bp_nxt;
	logic [3:0] cc_nxt;
	logic [3:0] fp_nxt;
	logic       hok_nxt;
	logic       stp_nxt;

	nsfe_pkg::map_res_t map_res;

	nsfe_slot_map u_map (
		.sentence_select (sentence_select),
		.comma_count     (cc_cur),
		.field_position  (fp_cur),
		.res             (map_res)
	);

	// Restart on first byte
	always_comb begin
		if (first) begin
			bp_cur  = '0;
			cc_cur  = '0;
			fp_cur  = '0;
			hok_cur = 1'b0;
			stp_cur = 1'b0;
		end else begin
			bp_cur  = byte_pos_q;
			cc_cur  = comma_cnt_q;
			fp_cur  = field_pos_q;
			hok_cur = header_ok_q;
			stp_cur = stopped_q;
		end
	end

	// Next state and result
	always_comb begin
		bp_nxt  = bp_cur;
		cc_nxt  = cc_cur;
		fp_nxt  = fp_cur;
		hok_nxt = hok_cur;
		stp_nxt = stp_cur;
		emit    = 1'b0;
		res     = map_res;
		if (!stp_cur) begin
			if (bp_cur >= 8'(nsfe_pkg::MAX_SENTENCE) || byte_in == nsfe_pkg::CHAR_NEWLINE) begin
				stp_nxt = 1'b1;
			end else if (bp_cur < 8'(nsfe_pkg::HDR_LEN) &&
					byte_in != nsfe_pkg::hdr_char(sentence_select, bp_cur[2:0])) begin
				stp_nxt = 1'b1;
			end else begin
				if (bp_cur == 8'(nsfe_pkg::HDR_LEN - 1)) begin
					hok_nxt = 1'b1;
				end
				if (bp_cur != 8'hFF) begin
					bp_nxt = bp_cur + 8'd1;
				end
				if (byte_in == nsfe_pkg::CHAR_COMMA) begin
					if (cc_cur < nsfe_pkg::COMMA_SAT) begin
						cc_nxt = cc_cur + 4'd1;
					end
					fp_nxt = '0;
				end else begin
					if (fp_cur < nsfe_pkg::FIELD_SAT) begin
						fp_nxt = fp_cur + 4'd1;
					end
					if (cc_cur > nsfe_pkg::COMMA_LAST) begin
						stp_nxt = 1'b1;
					end
					emit = map_res.hit && hok_nxt;
				end
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q  <= '0;
			comma_cnt_q <= '0;
			field_pos_q <= '0;
			header_ok_q <= 1'b0;
			stopped_q   <= 1'b1;
		end else if (accept) begin
			byte_pos_q  <= bp_nxt;
			comma_cnt_q <= cc_nxt;
			field_pos_q <= fp_nxt;
			header_ok_q <= hok_nxt;
			stopped_q   <= stp_nxt;
		end
	end

	// Checks
	a_comma_sat: assert property (@(posedge clk) disable iff (!arst_n)
		comma_cnt_q <= nsfe_pkg::COMMA_SAT)
		else $error("comma count beyond saturation");

	a_emit_header: assert property (@(posedge clk) disable iff (!arst_n)
		accept && emit |=> header_ok_q)
		else $error("result emitted without header match");

	a_stopped_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && !(accept && first) |=> stopped_q && $stable(byte_pos_q))
		else $error("stopped parser changed state without a first byte");

endmodule

### rtl/core/nmea_sentence_field_extractor.sv
// A result appears on the output in the cycle after its byte is taken.
// Throughput: one byte per cycle, stalled while a held result is not read;
// the output register frees in the cycle it is read; bytes with no result empty it.
// Reset: asynchronous; parser idle until a first byte, RMC selected.
// ----------------------------------------------------------------------------
// nmea_sentence_field_extractor: NMEA RMC/GGA field extractor
// APB register, parser state and one output register for slot characters.
// ----------------------------------------------------------------------------
module nmea_sentence_field_extractor (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        first,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  slot,
	output logic [2:0]  char_index,
	output logic [7:0]  character
);

	logic               sel_q;
	logic               accept;
	logic               emit;
	nsfe_pkg::map_res_t res;
	logic               out_valid_q;
	logic [4:0]         slot_q;
	logic [2:0]         idx_q;
	logic [7:0]         char_q;

	// APB register
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == nsfe_pkg::REG_SENTENCE_SELECT) begin
			prdata = {31'd0, sel_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= nsfe_pkg::SEL_RMC;
		end else if (psel && penable && pwrite &&
				paddr[2] == nsfe_pkg::REG_SENTENCE_SELECT) begin
			sel_q <= pwdata[0];
		end
	end

	// Input handshake
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	nsfe_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.byte_in         (byte_in),
		.first           (first),
		.sentence_select (sel_q),
		.emit            (emit),
		.res             (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			slot_q <= res.slot;
			idx_q  <= res.idx;
			char_q <= byte_in;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot       = slot_q;
	assign char_index = idx_q;
	assign character  = char_q;

	// Checks
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> slot_q <= nsfe_pkg::SLOT_ALT_UNIT)
		else $error("slot out of range");

	a_single_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (slot_q == nsfe_pkg::SLOT_VALID || slot_q == nsfe_pkg::SLOT_LAT_NS ||
		slot_q == nsfe_pkg::SLOT_LON_EW || slot_q == nsfe_pkg::SLOT_ALT_UNIT)
		|-> idx_q == 3'd0)
		else $error("single character slot with nonzero index");

	a_no_sep_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (byte_in == nsfe_pkg::CHAR_COMMA || byte_in == nsfe_pkg::CHAR_NEWLINE)
		|=> !out_valid_q)
		else $error("separator byte produced a result");

endmodule

### sim/nmea_field_checker.sv
// ----------------------------------------------------------------------------
// nmea_field_checker: result predictor and comparator for the field extractor
// Watches the APB write, byte and result channels, runs its own parser model
// and compares every accepted result against the oldest predicted one.
// ----------------------------------------------------------------------------
module nmea_field_checker (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	// byte channel
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  byte_in,
	input  logic        first,
	// result channel
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [4:0]  slot,
	input  logic [2:0]  char_index,
	input  logic [7:0]  character,
	// status to the testbench top
	output int          failures,
	output int          pending
);

	localparam logic [2:0] SELECT_ADDR = {nsfe_pkg::REG_SENTENCE_SELECT, 2'b00};

	typedef struct packed {
		logic [4:0] slot;
		logic [2:0] idx;
		logic [7:0] ch;
	} slot_char_t;

	// Parser model state
	logic       type_sel;
	logic [7:0] pos;
	logic [3:0] commas;
	logic [3:0] fpos;
	logic       hdr_ok;
	logic       halted;

	slot_char_t slot_char_q[$];
	slot_char_t oldest;
	slot_char_t fresh;
	logic       emit;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		failures++;
	endtask

	// Field split into three two-character slots
	function automatic nsfe_pkg::map_res_t pair_split(input logic [3:0] f,
			input logic [4:0] base);
		nsfe_pkg::map_res_t r;
		r = '0;
		if (f < 4'd6) begin
			r.hit  = 1'b1;
			r.slot = base + 5'(f >> 1);
			r.idx  = 3'(f[0]);
		end
		return r;
	endfunction

	// Degrees of dlen characters, then minutes up to mend
	function automatic nsfe_pkg::map_res_t coord_split(input logic [3:0] f,
			input logic [3:0] dlen, input logic [3:0] mend, input logic [4:0] base);
		nsfe_pkg::map_res_t r;
		r = '0;
		if (f < dlen) begin
			r.hit  = 1'b1;
			r.slot = base;
			r.idx  = 3'(f);
		end else if (f < mend) begin
			r.hit  = 1'b1;
			r.slot = base + 5'd1;
			r.idx  = 3'(f - dlen);
		end
		return r;
	endfunction

	function automatic nsfe_pkg::map_res_t plain_field(input logic [3:0] f,
			input logic [3:0] lim, input logic [4:0] s);
		nsfe_pkg::map_res_t r;
		r = '0;
		if (f < lim) begin
			r.hit  = 1'b1;
			r.slot = s;
			r.idx  = 3'(f);
		end
		return r;
	endfunction

	// Field number -> slot mapping, RMC
	function automatic nsfe_pkg::map_res_t rmc_lookup(input logic [3:0] c,
			input logic [3:0] f);
		case (c)
			4'd1:    return pair_split(f, nsfe_pkg::SLOT_HOUR);
			4'd2:    return plain_field(f, 4'd1, nsfe_pkg::SLOT_VALID);
			4'd3:    return coord_split(f, 4'd2, 4'd9, nsfe_pkg::SLOT_LAT_DEG);
			4'd4:    return plain_field(f, 4'd1, nsfe_pkg::SLOT_LAT_NS);
			4'd5:    return coord_split(f, 4'd3, 4'd10, nsfe_pkg::SLOT_LON_DEG);
			4'd6:    return plain_field(f, 4'd1, nsfe_pkg::SLOT_LON_EW);
			4'd7:    return plain_field(f, 4'd5, nsfe_pkg::SLOT_SPEED);
			4'd9:    return pair_split(f, nsfe_pkg::SLOT_DAY);
			default: return '0;
		endcase
	endfunction

	// Field number -> slot mapping, GGA
	function automatic nsfe_pkg::map_res_t gga_lookup(input logic [3:0] c,
			input logic [3:0] f);
		case (c)
			4'd1:    return pair_split(f, nsfe_pkg::SLOT_HOUR);
			4'd2:    return coord_split(f, 4'd2, 4'd9, nsfe_pkg::SLOT_LAT_DEG);
			4'd3:    return plain_field(f, 4'd1, nsfe_pkg::SLOT_LAT_NS);
			4'd4:    return coord_split(f, 4'd3, 4'd10, nsfe_pkg::SLOT_LON_DEG);
			4'd5:    return plain_field(f, 4'd1, nsfe_pkg::SLOT_LON_EW);
			4'd7:    return plain_field(f, 4'd2, nsfe_pkg::SLOT_SATS);
			4'd8:    return plain_field(f, 4'd3, nsfe_pkg::SLOT_ACCURACY);
			4'd9:    return plain_field(f, 4'd5, nsfe_pkg::SLOT_ALTITUDE);
			4'd10:   return plain_field(f, 4'd1, nsfe_pkg::SLOT_ALT_UNIT);
			default: return '0;
		endcase
	endfunction

	// Advance the parser model by one byte; hit tells whether a slot char results
	task automatic parse_byte(input logic [7:0] b, input logic start,
			output logic hit, output slot_char_t res);
		nsfe_pkg::map_res_t m;
		logic [47:0]        hdr;
		logic [7:0]         want;
		hit = 1'b0;
		res = '0;
		if (start) begin
			pos    = '0;
			commas = '0;
			fpos   = '0;
			hdr_ok = 1'b0;
			halted = 1'b0;
		end
		if (halted)
			return;
		// newline or length limit ends the sentence silently
		if (pos >= nsfe_pkg::MAX_SENTENCE || b == nsfe_pkg::CHAR_NEWLINE) begin
			halted = 1'b1;
			return;
		end
		// header compare against the type selected right now
		if (pos < nsfe_pkg::HDR_LEN) begin
			hdr  = (type_sel == nsfe_pkg::SEL_GGA) ? nsfe_pkg::HDR_GGA : nsfe_pkg::HDR_RMC;
			want = hdr[8 * (5 - pos) +: 8];
			if (b != want) begin
				halted = 1'b1;
				return;
			end
			if (pos == nsfe_pkg::HDR_LEN - 1)
				hdr_ok = 1'b1;
		end
		if (pos != 8'hFF)
			pos++;
		if (b == nsfe_pkg::CHAR_COMMA) begin
			if (commas < nsfe_pkg::COMMA_SAT)
				commas++;
			fpos = '0;
			return;
		end
		m = (type_sel == nsfe_pkg::SEL_GGA) ? gga_lookup(commas, fpos) :
			rmc_lookup(commas, fpos);
		if (fpos < nsfe_pkg::FIELD_SAT)
			fpos++;
		// first character after the tenth comma is the last one parsed
		if (commas > nsfe_pkg::COMMA_LAST)
			halted = 1'b1;
		if (m.hit && hdr_ok) begin
			hit = 1'b1;
			res = '{slot: m.slot, idx: m.idx, ch: b};
		end
	endtask

	// Compare results first, then predict for new bytes, then register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_sel = nsfe_pkg::SEL_RMC;
			pos      = '0;
			commas   = '0;
			fpos     = '0;
			hdr_ok   = 1'b0;
			halted   = 1'b1;
			slot_char_q.delete();
			pending  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (slot_char_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item slot %0d index %0d char 0x%02h",
						slot, char_index, character));
				end else begin
					oldest = slot_char_q.pop_front();
					if (slot !== oldest.slot)
						report_mismatch($sformatf("slot got %0d expected %0d", slot, oldest.slot));
					if (char_index !== oldest.idx)
						report_mismatch($sformatf("char_index got %0d expected %0d",
							char_index, oldest.idx));
					if (character !== oldest.ch)
						report_mismatch($sformatf("character got 0x%02h expected 0x%02h",
							character, oldest.ch));
				end
			end
			// a byte taken at this edge still sees the old register value
			if (in_valid && in_ready) begin
				parse_byte(byte_in, first, emit, fresh);
				if (emit)
					slot_char_q.push_back(fresh);
			end
			if (psel && penable && pwrite && pready && paddr == SELECT_ADDR)
				type_sel = pwdata[0];
			pending = slot_char_q.size();
		end
	end

endmodule

### sim/nmea_sentence_field_extractor_tb.sv
// ----------------------------------------------------------------------------
// nmea_sentence_field_extractor_tb: top of the field extractor testbench
// Drives reset, APB writes of the sentence type and byte stimulus (directed
// corner bytes, then random RMC/GGA sentences with noise), throttles the
// result side, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module nmea_sentence_field_extractor_tb;

	localparam logic [2:0] SELECT_ADDR  = {nsfe_pkg::REG_SENTENCE_SELECT, 2'b00};
	localparam int         ITEM_TARGET  = 950;
	localparam int         PHASES       = 6;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         TIME_LIMIT   = 4_000_000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  byte_in   = '0;
	logic        first     = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  slot;
	logic [2:0]  char_index;
	logic [7:0]  character;

	int failures;
	int pending;

	// Throttle knobs, set per phase
	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_req  = 0;
	int hold_ack  = 0;
	int hold_left = 0;
	int items_sent = 0;

	nmea_sentence_field_extractor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_in    (byte_in),
		.first      (first),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot       (slot),
		.char_index (char_index),
		.character  (character)
	);

	nmea_field_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_in    (byte_in),
		.first      (first),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.slot       (slot),
		.char_index (char_index),
		.character  (character),
		.failures   (failures),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#(TIME_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// Result side: long hold on request, otherwise random stalls
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_left = HOLD_CYCLES;
			hold_ack  = hold_req;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one byte item, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic start);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_in  <= b;
		first    <= start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop offering, let every expected item arrive, then a few spare cycles
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_select(input logic val);
		logic [31:0] d;
		d    = $urandom();
		d[0] = val;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SELECT_ADDR;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly digits, some dots, some arbitrary bytes
	function automatic logic [7:0] field_char;
		int roll;
		roll = $urandom_range(99);
		if (roll < 80)
			return 8'h30 + 8'($urandom_range(9));
		if (roll < 85)
			return 8'h2E;
		return 8'($urandom_range(255));
	endfunction

	// One sentence: header (mostly right), comma fields, then an ending
	task automatic send_sentence(input logic kind_sel);
		int          roll;
		int          bad_pos;
		int          nfields;
		int          flen;
		int          total;
		logic [47:0] hdr;
		logic [7:0]  ch;
		roll    = $urandom_range(99);
		hdr     = (kind_sel == nsfe_pkg::SEL_GGA) ? nsfe_pkg::HDR_GGA : nsfe_pkg::HDR_RMC;
		if (roll >= 80 && roll < 88)
			hdr = (kind_sel == nsfe_pkg::SEL_GGA) ? nsfe_pkg::HDR_RMC : nsfe_pkg::HDR_GGA;
		bad_pos = (roll >= 88) ? $urandom_range(5) : nsfe_pkg::HDR_LEN;
		// stray bytes ahead of a start
		if ($urandom_range(19) == 0)
			send_byte(8'($urandom_range(255)), 1'b0);
		for (int k = 0; k < nsfe_pkg::HDR_LEN; k++) begin
			ch = hdr[8 * (5 - k) +: 8];
			if (k == bad_pos)
				ch = 8'($urandom_range(255));
			send_byte(ch, k == 0);
		end
		total   = nsfe_pkg::HDR_LEN;
		roll    = $urandom_range(99);
		nfields = (roll < 15) ? 3 : $urandom_range(8, 12);
		for (int f = 0; f < nfields; f++) begin
			send_byte(nsfe_pkg::CHAR_COMMA, 1'b0);
			total++;
			flen = ($urandom_range(9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 9);
			for (int j = 0; j < flen; j++) begin
				send_byte(field_char(), $urandom_range(199) == 0);
				total++;
			end
		end
		// ending: run past the length limit, newline, or nothing
		if (roll < 15) begin
			while (total < nsfe_pkg::MAX_SENTENCE + 8) begin
				send_byte(8'h30 + 8'($urandom_range(9)), 1'b0);
				total++;
			end
		end else if (roll < 90) begin
			send_byte(nsfe_pkg::CHAR_NEWLINE, 1'b0);
		end
	endtask

	initial begin
		logic [47:0] hdr;
		int          target;
		int          mode;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corner bytes under the reset type (RMC)
		send_byte(8'h41, 1'b0);                       // ignored while idle
		hdr = nsfe_pkg::HDR_RMC;
		for (int k = 0; k < nsfe_pkg::HDR_LEN; k++)
			send_byte(hdr[8 * (5 - k) +: 8], k == 0);
		send_byte(nsfe_pkg::CHAR_COMMA, 1'b0);
		send_byte(8'h31, 1'b0);                       // hour
		send_byte(8'h32, 1'b0);
		send_byte(8'h33, 1'b0);                       // minute
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);                       // second
		send_byte(nsfe_pkg::CHAR_NEWLINE, 1'b0);      // ends the sentence
		send_byte(8'h35, 1'b0);                       // ignored after stop
		send_byte(8'h00, 1'b1);                       // bad header at first byte
		send_byte(8'h24, 1'b1);                       // GGA header under RMC
		send_byte(8'h47, 1'b0);
		send_byte(8'h50, 1'b0);
		send_byte(8'h47, 1'b0);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			mode = phase % 4;
			idle_pct  = (mode == 1) ? 60 : (mode == 3) ? 30 : 0;
			stall_pct = (mode == 2) ? 60 : (mode == 3) ? 30 : 0;
			write_select((phase % 2) ? nsfe_pkg::SEL_GGA : nsfe_pkg::SEL_RMC);

			// finish a sentence that was opened under the other type
			if (phase > 0) begin
				send_byte(8'h33, 1'b0);
				send_byte(8'h34, 1'b0);
				send_byte(nsfe_pkg::CHAR_COMMA, 1'b0);
				for (int j = 0; j < 4; j++)
					send_byte(field_char(), 1'b0);
				send_byte(nsfe_pkg::CHAR_NEWLINE, 1'b0);
			end

			// long result-side hold while bytes keep coming
			if (phase == 0)
				hold_req++;

			target = 20 + (phase + 1) * (ITEM_TARGET / PHASES);
			while (items_sent < target)
				send_sentence((phase % 2) ? nsfe_pkg::SEL_GGA : nsfe_pkg::SEL_RMC);

			// leave a sentence open across the next type change
			hdr = (phase % 2) ? nsfe_pkg::HDR_GGA : nsfe_pkg::HDR_RMC;
			for (int k = 0; k < nsfe_pkg::HDR_LEN; k++)
				send_byte(hdr[8 * (5 - k) +: 8], k == 0);
			send_byte(nsfe_pkg::CHAR_COMMA, 1'b0);
			send_byte(8'h31, 1'b0);
			send_byte(8'h32, 1'b0);
		end

		drain();
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
